// ===== rtl/rms_level_meter_smoothed_core_defines.svh =====
// ----------------------------------------------------------------------------
// rms_level_meter_smoothed_core_defines.svh
// Assertion macros shared by the RMS level meter RTL. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RMS_LEVEL_METER_SMOOTHED_CORE_DEFINES_SVH
`define RMS_LEVEL_METER_SMOOTHED_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check on every rising edge of clk, ignored while reset is held.
`define RLMS_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rlms assertion failed");
// Check on every rising edge of clk, reset included.
`define RLMS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rlms assertion failed (reset included)");
`else
`define RLMS_ASSERT_CLK(lbl, prop)
`define RLMS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/rlms_pkg.sv =====
// ----------------------------------------------------------------------------
// rlms_pkg
// Types and fixed constants of the RMS level meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlms_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int SUM_W      = 41;   // block square sum, saturating
  localparam int SQ_W       = 29;   // square of a halved sample, at most 2^28
  localparam int DIVD_W     = SUM_W + 2;  // 4 * square sum
  localparam int RAD_W      = 32;   // mean square fits in 31 bits, padded even
  localparam int DIV_STEPS  = DIVD_W;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int STEP_W     = 6;
  localparam int SQREM_W    = LEVEL_W + 2;
  localparam int ACC_W      = 32;
  localparam int QDEPTH     = 2;

  localparam logic [LEVEL_W-1:0] KEEP_COEF  = 16'd60948;  // 0.93 in Q0.16
  localparam logic [LEVEL_W-1:0] NEW_COEF   = 16'd4588;   // 0.07 in Q0.16
  localparam logic [ACC_W-1:0]   ROUND_HALF = 32'h0000_8000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [SUM_W-1:0]           sum_t;
  typedef logic [SQ_W-1:0]            square_t;

endpackage

`default_nettype wire

// ===== rtl/rlms_front.sv =====
// ----------------------------------------------------------------------------
// rlms_front
// Sample front end: halve, square, accumulate and count; hand each closed
// block (sum, count, freeze flag) to the block queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlms_front #(
  parameter int MAX_BLOCK = 4096,
  parameter int CNT_W     = 13
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire                        cfg_wdata,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire rlms_pkg::sample_t     in_sample,
  input  wire                        in_last_of_block,
  output logic                       push,
  output logic [rlms_pkg::SUM_W+CNT_W:0] push_data,
  input  wire                        q_full
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK);

  logic                   frozen_r, frozen_nxt;
  logic                   s1_v_r, s1_v_nxt;
  logic                   s1_last_r;
  rlms_pkg::square_t      s1_sq_r;
  rlms_pkg::sum_t         sum_r, sum_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  rlms_pkg::sample_t      half;
  logic signed [31:0]     sq_full;
  logic                   s1_hold;
  logic                   accept;
  logic                   counted;
  logic [rlms_pkg::SUM_W:0] sum_ext;
  rlms_pkg::sum_t         sum_add;
  logic [CNT_W-1:0]       cnt_add;

  assign half    = in_sample >>> 1;
  assign sq_full = half * half;

  // hold a block end in stage 1 while the queue is full
  assign s1_hold  = s1_v_r & s1_last_r & q_full;
  assign in_stall = s1_hold;
  assign accept   = in_valid & ~s1_hold;

  assign counted = (cnt_r < CNT_MAX);
  assign sum_ext = {1'b0, sum_r} + (rlms_pkg::SUM_W+1)'(s1_sq_r);
  assign sum_add = !counted ? sum_r :
                   (sum_ext[rlms_pkg::SUM_W] ? '1 : sum_ext[rlms_pkg::SUM_W-1:0]);
  assign cnt_add = counted ? cnt_r + CNT_W'(1) : cnt_r;

  assign push      = s1_v_r & s1_last_r & ~q_full;
  assign push_data = {frozen_r, sum_add, cnt_add};

  always_comb begin
    frozen_nxt = cfg_we ? cfg_wdata : frozen_r;
    s1_v_nxt   = s1_hold ? s1_v_r : accept;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    if (s1_v_r && !s1_hold) begin
      if (s1_last_r) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r <= 1'b0;
      s1_v_r   <= 1'b0;
      sum_r    <= '0;
      cnt_r    <= '0;
    end else begin
      frozen_r <= frozen_nxt;
      s1_v_r   <= s1_v_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sq_r   <= sq_full[rlms_pkg::SQ_W-1:0];
      s1_last_r <= in_last_of_block;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rlms_fifo.sv =====
// ----------------------------------------------------------------------------
// rlms_fifo
// Short block queue between the sample front end and the block back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rms_level_meter_smoothed_core_defines.svh"

module rlms_fifo #(
  parameter int W     = 55,
  parameter int DEPTH = 2
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire [W-1:0]  push_data,
  output logic         full,
  input  wire          pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  assign full     = (fill_r == FILL_MAX);
  assign empty    = (fill_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `RLMS_ASSERT_CLK(a_no_push_when_full, push |-> !full)
  `RLMS_ASSERT_CLK(a_no_pop_when_empty, pop |-> !empty)
  `RLMS_ASSERT_CLK(a_fill_in_range, fill_r <= FILL_MAX)

endmodule

`default_nettype wire

// ===== rtl/rlms_back.sv =====
// ----------------------------------------------------------------------------
// rlms_back
// Block back end: restoring divide of 4*sum by count, bit-pair square root,
// two-step smoothing multiply and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rms_level_meter_smoothed_core_defines.svh"

module rlms_back #(
  parameter int CNT_W = 13
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_empty,
  input  wire [rlms_pkg::SUM_W+CNT_W:0]    q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire                              out_stall,
  output rlms_pkg::level_t                 out_level
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam int DW = rlms_pkg::DIVD_W;
  localparam int RW = rlms_pkg::RAD_W;
  localparam int SW = rlms_pkg::SQREM_W;
  localparam int LW = rlms_pkg::LEVEL_W;
  localparam int AW = rlms_pkg::ACC_W;

  logic [2:0]                  state_r, state_nxt;
  logic [rlms_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic [DW-1:0]               dq_r, dq_nxt;
  logic [RW-1:0]               rad_r, rad_nxt;
  logic [SW-1:0]               sqrem_r, sqrem_nxt;
  rlms_pkg::level_t            root_r, root_nxt;
  logic [AW-1:0]               prod_r, prod_nxt;
  rlms_pkg::level_t            level_r, level_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rlms_pkg::level_t            out_level_r, out_level_nxt;

  logic                        q_frozen;
  rlms_pkg::sum_t              q_sum;
  logic [CNT_W-1:0]            q_cnt;
  logic [CNT_W:0]              rem_sh;
  logic [CNT_W:0]              rem_diff;
  logic                        div_ge;
  logic [SW+1:0]               sq_cur;
  logic [SW+1:0]               sq_trial;
  logic [SW+1:0]               sq_diff;
  logic                        sq_ge;
  logic [AW-1:0]               acc;
  logic                        out_free;

  assign q_frozen = q_data[rlms_pkg::SUM_W+CNT_W];
  assign q_sum    = q_data[rlms_pkg::SUM_W+CNT_W-1:CNT_W];
  assign q_cnt    = q_data[CNT_W-1:0];

  // one quotient bit per cycle
  assign rem_sh   = {rem_r, dq_r[DW-1]};
  assign div_ge   = (rem_sh >= {1'b0, cnt_r});
  assign rem_diff = rem_sh - {1'b0, cnt_r};

  // one root bit per cycle
  assign sq_cur   = {sqrem_r, rad_r[RW-1:RW-2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);
  assign sq_diff  = sq_cur - sq_trial;

  assign acc = prod_r + AW'(root_r * rlms_pkg::NEW_COEF) + rlms_pkg::ROUND_HALF;

  assign out_free = ~out_valid_r | ~out_stall;
  assign q_pop    = (state_r == ST_IDLE) & ~q_empty;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    rad_nxt       = rad_r;
    sqrem_nxt     = sqrem_r;
    root_nxt      = root_r;
    prod_nxt      = prod_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_level_nxt = out_level_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_frozen) begin
            state_nxt = ST_OUT;
          end else if (q_cnt == '0) begin
            root_nxt  = '0;
            state_nxt = ST_MUL1;
          end else begin
            dq_nxt    = {q_sum, 2'b00};
            cnt_nxt   = q_cnt;
            rem_nxt   = '0;
            step_nxt  = rlms_pkg::STEP_W'(rlms_pkg::DIV_STEPS - 1);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dq_nxt  = {dq_r[DW-2:0], div_ge};
        step_nxt = step_r - rlms_pkg::STEP_W'(1);
        if (step_r == '0) begin
          // mean square is at most 2^30, upper quotient bits are zero
          rad_nxt   = dq_nxt[RW-1:0];
          sqrem_nxt = '0;
          root_nxt  = '0;
          step_nxt  = rlms_pkg::STEP_W'(rlms_pkg::SQRT_STEPS - 1);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sqrem_nxt = sq_ge ? sq_diff[SW-1:0] : sq_cur[SW-1:0];
        root_nxt  = {root_r[LW-2:0], sq_ge};
        rad_nxt   = {rad_r[RW-3:0], 2'b00};
        step_nxt  = step_r - rlms_pkg::STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        prod_nxt  = AW'(level_r * rlms_pkg::KEEP_COEF);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        level_nxt = acc[AW-1:AW-LW];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    rad_r       <= rad_nxt;
    sqrem_r     <= sqrem_nxt;
    root_r      <= root_nxt;
    prod_r      <= prod_nxt;
    out_level_r <= out_level_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  `RLMS_ASSERT_CLK(a_pop_only_idle, q_pop |-> state_r == ST_IDLE)
  `RLMS_ASSERT_CLK(a_div_nonzero, state_r == ST_DIV |-> cnt_r != '0)
  `RLMS_ASSERT_CLK(a_rms_bounded, state_r == ST_MUL1 |-> root_r <= 16'h8000)

endmodule

`default_nettype wire

// ===== rtl/rms_level_meter_smoothed_core.sv =====
// Path: from the edge that takes the last sample of a block to its level beat
//   go the front stage register, the block queue, 43 divide steps, 16 root
//   steps, 2 multiply steps and the out register; a frozen block skips the math.
// Throughput: one sample per cycle unless a block end waits on a full queue; the
//   serial divider and root unit take one block at a time; two block ends may queue.
// Reset: synchronous, active low; sums, count, level and freeze flag clear.
// ----------------------------------------------------------------------------
// rms_level_meter_smoothed_core
// Smoothed RMS level meter: sums squared half-samples per block, then forms
// isqrt(4*sum/count) and updates level = level*0.93 + rms*0.07 per unfrozen block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rms_level_meter_smoothed_core #(
  parameter int MAX_BLOCK = 4096
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // freeze register
  input  wire                    cfg_we,
  input  wire                    cfg_wdata,
  // sample beats
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire rlms_pkg::sample_t in_sample,
  input  wire                    in_last_of_block,
  // level beats
  output logic                   out_valid,
  input  wire                    out_stall,
  output rlms_pkg::level_t       out_level
);

  // Count must hold MAX_BLOCK itself, where it saturates.
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  // Queue entry: freeze flag, block square sum, block count.
  localparam int QW    = 1 + rlms_pkg::SUM_W + CNT_W;

  logic          push;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_data;
  logic          q_empty;

  // Front: take one sample beat per cycle, halve and square it, accumulate.
  // Stall only when a block end waits on a full queue.
  rlms_front #(
    .MAX_BLOCK (MAX_BLOCK),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last_of_block (in_last_of_block),
    .push             (push),
    .push_data        (push_data),
    .q_full           (q_full)
  );

  // Queue of closed blocks lets the front keep streaming while the back works.
  rlms_fifo #(
    .W     (QW),
    .DEPTH (rlms_pkg::QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // Back: divide, root, smooth, then present the level in the out register.
  // A frozen block skips the math and reports the kept level.
  rlms_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (out_level)
  );

endmodule

`default_nettype wire

// ===== bench/level_monitor.sv =====
// ----------------------------------------------------------------------------
// level_monitor
// Watches the sample, level and freeze ports of the RMS level meter, keeps its
// own copy of the block sums and the smoothed level, and compares every level
// beat against the oldest predicted level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module level_monitor #(
  parameter int MAX_BLOCK = 4096
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire                    cfg_wdata,
  input  wire                    in_valid,
  input  wire                    in_stall,
  input  wire rlms_pkg::sample_t in_sample,
  input  wire                    in_last_of_block,
  input  wire                    out_valid,
  input  wire                    out_stall,
  input  wire rlms_pkg::level_t  out_level,
  output int                     mismatches,
  output int                     pending_levels
);

  localparam logic [63:0] SUM_CEILING = (64'd1 << rlms_pkg::SUM_W) - 64'd1;

  rlms_pkg::sum_t   square_sum;
  int               block_count;
  rlms_pkg::level_t smoothed_level;
  logic             level_frozen;
  rlms_pkg::level_t expected_levels[$];

  // Floor of the square root, digit by digit.
  function automatic rlms_pkg::level_t isqrt_floor(input logic [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = radicand;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return rlms_pkg::level_t'(root);
  endfunction

  // Add one sample to the running block; close the block on its last beat.
  task automatic fold_sample(input rlms_pkg::sample_t value, input logic closes);
    logic signed [31:0] half;
    logic [63:0]        grown;
    logic [63:0]        blend;
    rlms_pkg::level_t   rms;
    if (block_count < MAX_BLOCK) begin
      half  = value;
      half  = half >>> 1;
      grown = 64'(square_sum) + 64'(half * half);
      square_sum  = (grown > SUM_CEILING) ? rlms_pkg::sum_t'(SUM_CEILING)
                                          : rlms_pkg::sum_t'(grown);
      block_count = block_count + 1;
    end
    if (closes) begin
      if (!level_frozen) begin
        rms = '0;
        if (block_count != 0)
          rms = isqrt_floor((64'(square_sum) << 2) / 64'(block_count));
        blend = 64'(smoothed_level) * rlms_pkg::KEEP_COEF
              + 64'(rms) * rlms_pkg::NEW_COEF + 64'(rlms_pkg::ROUND_HALF);
        blend = blend >> 16;
        smoothed_level = (blend > 64'hFFFF) ? 16'hFFFF : rlms_pkg::level_t'(blend);
      end
      square_sum  = '0;
      block_count = 0;
      expected_levels = {expected_levels, smoothed_level};
    end
  endtask

  initial begin
    mismatches     = 0;
    pending_levels = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      square_sum     = '0;
      block_count    = 0;
      smoothed_level = '0;
      level_frozen   = 1'b0;
      expected_levels.delete();
    end else begin
      if (cfg_we) level_frozen = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          if (mismatches < 10)
            $display("level beat with nothing expected: got %0d", out_level);
          mismatches = mismatches + 1;
        end else if (out_level !== expected_levels[0]) begin
          if (mismatches < 10)
            $display("level mismatch: expected %0d, got %0d",
                     expected_levels[0], out_level);
          mismatches = mismatches + 1;
          void'(expected_levels.pop_front());
        end else begin
          void'(expected_levels.pop_front());
        end
      end
      if (in_valid && !in_stall) fold_sample(in_sample, in_last_of_block);
    end
    pending_levels = expected_levels.size();
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives sample beats grouped in blocks into the smoothed RMS level meter,
// toggles the freeze register between phases, and lets level_monitor predict
// and compare every level beat. Both channels idle at random, two
// phases run with no idling, and the level sink holds off once for a long stretch so the
// meter backs up and stalls its sample input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Small block limit so overlong blocks stay short.
  localparam int          MAX_BLOCK        = 256;
  localparam int          RESET_CYCLES     = 7;
  // Roughly the block-end latency plus margin; used before freeze writes and
  // at the end of the run.
  localparam int          DRAIN_CYCLES     = 100;
  localparam int          WATCHDOG_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD_AFTER  = 20;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned PHASE_SAMPLES    = 200;
  localparam int          RANDOM_PHASES    = 6;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  rlms_pkg::sample_t in_sample;
  logic              in_last_of_block;
  logic              out_valid;
  logic              out_stall;
  rlms_pkg::level_t  out_level;

  int                mismatches;
  int                pending_levels;
  int                idle_cycles = 0;
  // Set by the stimulus for phases that run with no gaps on either side.
  logic              no_idle = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rms_level_meter_smoothed_core #(
    .MAX_BLOCK(MAX_BLOCK)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_last_of_block(in_last_of_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level)
  );

  level_monitor #(
    .MAX_BLOCK(MAX_BLOCK)
  ) monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_last_of_block(in_last_of_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .mismatches      (mismatches),
    .pending_levels  (pending_levels)
  );

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Level sink: draw a stall stretch after every accepted beat. After the
  // LONG_HOLD_AFTER-th level, hold off long enough that two block ends queue
  // inside the meter and it has to stall the sample side.
  initial begin : level_sink
    int unsigned hold_left;
    int unsigned taken;
    hold_left = 0;
    taken     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = (hold_left != 0);
      if (hold_left != 0) hold_left = hold_left - 1;
      @(posedge clk);
      if (out_valid && !out_stall) begin
        taken = taken + 1;
        if (taken == LONG_HOLD_AFTER) begin
          hold_left = LONG_HOLD_CYCLES;
        end else begin
          hold_left = no_idle ? 0 : $urandom_range(0, 5);
        end
      end
    end
  end

  // Offer one sample beat after a random gap; hold it until accepted.
  task automatic send_beat(input rlms_pkg::sample_t value, input logic closes);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_sample        = value;
    in_last_of_block = closes;
    do @(posedge clk); while (in_stall);
  endtask

  // Send a whole block of one repeated sample.
  task automatic send_block(input rlms_pkg::sample_t value, input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) send_beat(value, i == len - 1);
  endtask

  // Drop valid, wait for every predicted level to come back, then let the
  // meter's back end go quiet before touching the register.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_levels != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_freeze(input logic frozen);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = frozen;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Mostly full-scale random samples, scaled down per block now and then,
  // with the two rails mixed in.
  function automatic rlms_pkg::sample_t draw_sample(input int unsigned shift);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return rlms_pkg::sample_t'($urandom) >>> shift;
    endcase
  endfunction

  // Random blocks: mostly short, some medium, a few long.
  task automatic random_phase(input int unsigned quota);
    int unsigned sent;
    int unsigned len;
    int unsigned shift;
    int unsigned pick;
    int unsigned i;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 6);
      else if (pick < 95) len = $urandom_range(7, 40);
      else len = $urandom_range(41, 300);
      shift = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      for (i = 0; i < len; i++) send_beat(draw_sample(shift), i == len - 1);
      sent = sent + len;
    end
  endtask

  initial begin : stimulus
    int phase;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_valid         = 1'b0;
    in_sample        = '0;
    in_last_of_block = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    write_freeze(1'b0);
    // Single-sample blocks at the rails, zero and around zero, where the
    // halving rounds toward minus infinity.
    send_block(16'sh0000, 1);
    send_block(16'sh7FFF, 1);
    send_block(16'sh8000, 1);
    send_block(-16'sd1, 1);
    send_block(16'sd1, 1);
    send_block(-16'sd2, 1);
    // Mixed two-sample block, then a short loud one.
    send_beat(16'sd16384, 1'b0);
    send_beat(-16'sd16385, 1'b1);
    send_block(16'sh7FFF, 3);
    // Overlong block: the count saturates at MAX_BLOCK, the tail is dropped
    // from the sum and the last beat still closes the block.
    send_block(16'sh8000, MAX_BLOCK + 4);
    settle();

    // Frozen: blocks still clear the sums, the level holds and is reported.
    write_freeze(1'b1);
    send_block(16'sh7FFF, 3);
    send_block(16'sh8000, 1);
    send_block(16'sh0000, 2);
    settle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_freeze(phase == 3);
      no_idle = (phase == 2 || phase == 5);
      random_phase(PHASE_SAMPLES);
      settle();
    end

    if (mismatches == 0 && pending_levels == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rlms_pkg.sv
rtl/rlms_front.sv
rtl/rlms_fifo.sv
rtl/rlms_back.sv
rtl/rms_level_meter_smoothed_core.sv
bench/level_monitor.sv
bench/testbench.sv
